@@ design/ipf_pkg.sv @@
// ----------------------------------------------------------------------------
// ipf_pkg: shared types and float helpers
// Stage records, register indexes and rounding functions for the pixel
// to float scale/offset converter.
// ----------------------------------------------------------------------------
package ipf_pkg;

    localparam int unsigned EXP_W = 12;
    typedef logic signed [EXP_W-1:0] exp_t;

    localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

    localparam logic [7:0] REG_SCALE  = 8'd0;
    localparam logic [7:0] REG_OFFSET = 8'd1;
    localparam logic [7:0] REG_WORD   = 8'd2;
    localparam logic [7:0] REG_HALF   = 8'd3;

    typedef struct packed {
        logic [31:0] scale;
        logic [31:0] offset;
        logic        src_word;
        logic        dst_half;
    } cfg_t;

    typedef struct packed {
        logic        spec;
        logic [31:0] spec_val;
        logic [39:0] prod;
        exp_t        pexp;
        logic        psign;
        logic [23:0] omant;
        exp_t        oexp;
        logic        osign;
        logic        last;
    } mul_t;

    typedef struct packed {
        logic        spec;
        logic [31:0] spec_val;
        logic [63:0] sum;
        exp_t        sexp;
        logic        ssign;
        logic        last;
    } add_t;

    // leading zero count, 64 for an all-zero word
    function automatic logic [6:0] lzc64(input logic [63:0] x);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) n = 7'(63 - i);
        end
        return n;
    endfunction

    // shift right by k (40..127), round to nearest even
    function automatic logic [24:0] rnd_shift(input logic [63:0] mn, input logic [6:0] k);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        q = '0;
        if (k > 7'd64) begin
            q = '0;
        end else if (k == 7'd64) begin
            q = (mn > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
        end else begin
            q    = mn >> k;
            rem  = mn & ((64'd1 << k) - 64'd1);
            half = 64'd1 << (k - 7'd1);
            if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        end
        return q[24:0];
    endfunction

    // round sign * m * 2^e (m nonzero) into a format of fb fraction bits
    function automatic logic [31:0] round_pack(input logic sign, input logic [63:0] m,
                                               input exp_t e, input int fb, input int bias,
                                               input int sbit);
        logic [6:0]  lz;
        logic [63:0] mn;
        exp_t        be;
        exp_t        kw;
        logic [6:0]  k;
        exp_t        base;
        logic [24:0] q;
        logic [39:0] r;
        logic [39:0] infv;
        lz = lzc64(m);
        mn = m << lz;
        be = exp_t'(63) - exp_t'(lz) + e + exp_t'(bias);
        if (be >= exp_t'(1)) begin
            k    = 7'(63 - fb);
            base = be - exp_t'(1);
        end else begin
            kw   = exp_t'(64 - fb) - be;
            k    = (kw > exp_t'(127)) ? 7'd127 : kw[6:0];
            base = '0;
        end
        q    = rnd_shift(mn, k);
        r    = (40'(unsigned'(base)) << fb) + 40'(q);
        infv = 40'(2 * bias + 1) << fb;
        if (r >= infv) r = infv;
        return r[31:0] | (32'(sign) << sbit);
    endfunction

endpackage

@@ design/ipf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ipf_cfg_regs: configuration registers
// Holds scale, offset and the two mode bits written over the config channel.
// ----------------------------------------------------------------------------
module ipf_cfg_regs
    import ipf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scale    <= 32'h3F80_0000;
            cfg_reg.offset   <= '0;
            cfg_reg.src_word <= 1'b0;
            cfg_reg.dst_half <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SCALE:  cfg_reg.scale    <= cfg_data;
                REG_OFFSET: cfg_reg.offset   <= cfg_data;
                REG_WORD:   cfg_reg.src_word <= cfg_data[0];
                REG_HALF:   cfg_reg.dst_half <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

@@ design/ipf_mul_stage.sv @@
// ----------------------------------------------------------------------------
// ipf_mul_stage: input register and product stage
// Registers the pixel, forms the exact product with the scale mantissa and
// resolves NaN, infinity and zero cases.
// ----------------------------------------------------------------------------
module ipf_mul_stage
    import ipf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [15:0] in_pixel,
    input  logic        in_last,
    input  cfg_t        cfg,
    output logic        out_valid,
    output mul_t        out_rec
);

    logic        v0_reg;
    logic [15:0] pix_reg;
    logic        last_reg;
    logic        v1_reg;
    mul_t        rec_reg;
    mul_t        rec_next;

    logic [31:0] sc, of;
    logic        sc_nan, of_nan, sc_inf, of_inf, pix_zero;
    logic [23:0] ms;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pix_reg  <= cfg.src_word ? in_pixel : {8'd0, in_pixel[7:0]};
            last_reg <= in_last;
            rec_reg  <= rec_next;
        end
    end

    always_comb begin
        sc       = cfg.scale;
        of       = cfg.offset;
        sc_nan   = (&sc[30:23]) && (|sc[22:0]);
        of_nan   = (&of[30:23]) && (|of[22:0]);
        sc_inf   = sc[30:0] == 31'h7F80_0000;
        of_inf   = of[30:0] == 31'h7F80_0000;
        pix_zero = pix_reg == '0;
        ms       = (sc[30:23] == '0) ? {1'b0, sc[22:0]} : {1'b1, sc[22:0]};

        rec_next.prod  = ms * pix_reg;
        rec_next.pexp  = (sc[30:23] == '0) ? -exp_t'(149) : exp_t'(sc[30:23]) - exp_t'(150);
        rec_next.psign = sc[31];
        rec_next.omant = (of[30:23] == '0) ? {1'b0, of[22:0]} : {1'b1, of[22:0]};
        rec_next.oexp  = (of[30:23] == '0) ? -exp_t'(149) : exp_t'(of[30:23]) - exp_t'(150);
        rec_next.osign = of[31];
        rec_next.last  = last_reg;

        rec_next.spec     = 1'b1;
        rec_next.spec_val = '0;
        priority if (of_nan && of[22] && sc_inf && pix_zero) begin
            rec_next.spec_val = DEFAULT_NAN;
        end else if (of_nan && !of[22]) begin
            rec_next.spec_val = of | QUIET_BIT;
        end else if (sc_nan && !sc[22]) begin
            rec_next.spec_val = sc | QUIET_BIT;
        end else if (of_nan) begin
            rec_next.spec_val = of;
        end else if (sc_nan) begin
            rec_next.spec_val = sc;
        end else if (sc_inf) begin
            if (pix_zero || (of_inf && (of[31] != sc[31])))
                rec_next.spec_val = DEFAULT_NAN;
            else
                rec_next.spec_val = sc;
        end else if (of_inf) begin
            rec_next.spec_val = of;
        end else if (pix_zero || sc[30:0] == '0) begin
            // zero product: offset passes, two zeros combine by sign
            rec_next.spec_val = (of[30:0] == '0) ? {sc[31] & of[31], 31'd0} : of;
        end else begin
            rec_next.spec = 1'b0;
        end
    end

    assign out_valid = v1_reg;
    assign out_rec   = rec_reg;

endmodule

@@ design/ipf_add_stage.sv @@
// ----------------------------------------------------------------------------
// ipf_add_stage: alignment and addition
// Normalises product and offset, aligns the smaller with a sticky bit and
// adds or subtracts the magnitudes.
// ----------------------------------------------------------------------------
module ipf_add_stage
    import ipf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  mul_t in_rec,
    output logic out_valid,
    output add_t out_rec
);

    logic        v_reg;
    add_t        rec_reg;
    add_t        rec_next;

    logic [63:0] pw, ow, pn, on, big, sml, bs;
    logic [6:0]  lzp, lzo;
    exp_t        pe, oe, eb, d;
    logic        sb, ssm;

    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= 1'b0;
        else if (en)  v_reg <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) rec_reg <= rec_next;
    end

    always_comb begin
        pw  = {24'd0, in_rec.prod};
        ow  = {40'd0, in_rec.omant};
        lzp = lzc64(pw);
        lzo = lzc64(ow);
        // top bit to position 62
        pn  = pw << (lzp - 7'd1);
        on  = ow << (lzo - 7'd1);
        pe  = in_rec.pexp - exp_t'(lzp) + exp_t'(1);
        oe  = in_rec.oexp - exp_t'(lzo) + exp_t'(1);

        if (in_rec.omant == '0) begin
            big = pn; rec_next.sexp = pe; sb = in_rec.psign;
            sml = '0; eb = pe; ssm = in_rec.psign;
        end else if (pe >= oe) begin
            big = pn; rec_next.sexp = pe; sb = in_rec.psign;
            sml = on; eb = oe; ssm = in_rec.osign;
        end else begin
            big = on; rec_next.sexp = oe; sb = in_rec.osign;
            sml = pn; eb = pe; ssm = in_rec.psign;
        end

        d = rec_next.sexp - eb;
        if (sml == '0)
            bs = '0;
        else if (d >= exp_t'(63))
            bs = 64'd1;
        else
            bs = (sml >> d[5:0]) | 64'(|(sml & ((64'd1 << d[5:0]) - 64'd1)));

        if (sb == ssm) begin
            rec_next.sum   = big + bs;
            rec_next.ssign = sb;
        end else if (big >= bs) begin
            rec_next.sum   = big - bs;
            rec_next.ssign = sb;
        end else begin
            rec_next.sum   = bs - big;
            rec_next.ssign = ssm;
        end

        rec_next.spec     = in_rec.spec;
        rec_next.spec_val = in_rec.spec_val;
        rec_next.last     = in_rec.last;
    end

    assign out_valid = v_reg;
    assign out_rec   = rec_reg;

endmodule

@@ design/ipf_pack_stage.sv @@
// ----------------------------------------------------------------------------
// ipf_pack_stage: rounding and output register
// Rounds the sum to single precision, then optionally to half precision,
// and holds the result item for the receiver.
// ----------------------------------------------------------------------------
module ipf_pack_stage
    import ipf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  add_t        in_rec,
    input  logic        dst_half,
    output logic        out_valid,
    output logic [31:0] out_bits,
    output logic        out_last
);

    logic        v3_reg, v4_reg;
    logic [31:0] f_reg, f_next;
    logic        l3_reg;
    logic [31:0] r_reg, r_next;
    logic        l4_reg;

    logic [23:0] hm;
    exp_t        he;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_reg  <= f_next;
            l3_reg <= in_rec.last;
            r_reg  <= r_next;
            l4_reg <= l3_reg;
        end
    end

    always_comb begin
        if (in_rec.spec)
            f_next = in_rec.spec_val;
        else if (in_rec.sum == '0)
            f_next = '0;
        else
            f_next = round_pack(in_rec.ssign, in_rec.sum, in_rec.sexp, 23, 127, 31);
    end

    always_comb begin
        hm = (f_reg[30:23] == '0) ? {1'b0, f_reg[22:0]} : {1'b1, f_reg[22:0]};
        he = (f_reg[30:23] == '0) ? -exp_t'(149) : exp_t'(f_reg[30:23]) - exp_t'(150);
        if (!dst_half)
            r_next = f_reg;
        else if (&f_reg[30:23])
            r_next = (f_reg[22:0] != '0)
                   ? {16'd0, f_reg[31], 15'h7E00 | 15'(f_reg[22:13])}
                   : {16'd0, f_reg[31], 15'h7C00};
        else if (hm == '0)
            r_next = {16'd0, f_reg[31], 15'd0};
        else
            r_next = {16'd0, 16'(round_pack(f_reg[31], {40'd0, hm}, he, 10, 15, 15))};
    end

    assign out_valid = v4_reg;
    assign out_bits  = r_reg;
    assign out_last  = l4_reg;

endmodule

@@ design/int_pixel_to_float_scale_offset_top.sv @@
// ----------------------------------------------------------------------------
// int_pixel_to_float_scale_offset_top: pixel to float with scale and offset
// Converts unsigned pixels to pixel*scale+offset as a fused float32 operation,
// optionally rounded on to binary16.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one pixel per item (tdata) and the row-end flag (tlast).
//   m_ channel returns the float32 pattern, or binary16 in the low 16 bits,
//   with tlast copied from the input item.
//   cfg_ channel writes scale (index 0), offset (1), word mode (2) and half
//   mode (3); it is always ready. The user must see that it is written only
//   while the block is empty; the block itself does not enforce this. An
//   accepted item reaches m_tvalid through five registers: input register,
//   product, alignment/add, float32 rounding, half rounding into the output
//   register. Throughput is one item per cycle while the receiver does not
//   stall; the five-register pipeline moves as one. When the receiver stalls
//   with a result waiting, the whole pipeline holds and s_tready drops; empty
//   slots are filled while the output is free. Reset clears all valid flags
//   and loads scale 1.0, offset 0, byte mode and float32 output.
// ----------------------------------------------------------------------------
module int_pixel_to_float_scale_offset_top
    import ipf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] pixel_value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_bits
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t cfg;
    logic en;
    logic v1, v2;
    mul_t mrec;
    add_t arec;

    // advance while the output slot is free or being taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    ipf_cfg_regs u_cfg (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg
    );

    ipf_mul_stage u_mul (
        .aclk, .aresetn, .en,
        .in_valid (s_tvalid), .in_pixel (s_tdata), .in_last (s_tlast), .cfg,
        .out_valid (v1), .out_rec (mrec)
    );

    ipf_add_stage u_add (
        .aclk, .aresetn, .en,
        .in_valid (v1), .in_rec (mrec),
        .out_valid (v2), .out_rec (arec)
    );

    ipf_pack_stage u_pack (
        .aclk, .aresetn, .en,
        .in_valid (v2), .in_rec (arec), .dst_half (cfg.dst_half),
        .out_valid (m_tvalid), .out_bits (m_tdata), .out_last (m_tlast)
    );

    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("result valid right after reset");

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready)) else $error("input ready mismatch");

    a_half_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && cfg.dst_half |-> m_tdata[31:16] == 16'd0)
        else $error("half result with upper bits set");

endmodule

@@ tb/tb_int_pixel_to_float_scale_offset_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for int_pixel_to_float_scale_offset_top
// Streams pixels through the scale/offset converter under random source gaps
// and sink stalls, across register settings that include infinities, NaNs,
// subnormals and overflow. Each result is checked against a bit-exact
// fused multiply-add and binary16 rounding model held in the bench.
// ----------------------------------------------------------------------------
module tb_int_pixel_to_float_scale_offset_top;
    import ipf_pkg::*;

    typedef struct {
        bit [15:0] pix;
        bit        last;
        bit [31:0] res;
    } pixel_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // bench copy of the registers
    bit [31:0] cur_scale = 32'h3F80_0000;
    bit [31:0] cur_offset = '0;
    bit        cur_word = 1'b0;
    bit        cur_half = 1'b0;

    pixel_item_t pending_pixels[$];
    bit [32:0]   expected_results[$];   // {last, result}
    bit          idling_on = 1'b1;
    int          errors = 0;
    int          cycles = 0;
    int          src_gap = 0;
    int          sink_stall = 0;

    int_pixel_to_float_scale_offset_top dut (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int msb_pos(bit [63:0] x);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++) if (x[i]) n = i;
        return n;
    endfunction

    // round sgn * m * 2^e (m nonzero) to fb fraction bits, nearest even
    function automatic bit [31:0] pack_rounded(bit sgn, bit [63:0] m, int e,
                                               int fb, int bias, int sbit);
        int        n, be, sh;
        bit [63:0] q, base, infv, rem, hlf, r;
        n    = msb_pos(m);
        be   = n + e + bias;
        sh   = (be >= 1) ? n - fb : 1 - bias - fb - e;
        base = (be >= 1) ? 64'(be - 1) : 64'd0;
        infv = 64'(2 * bias + 1) << fb;
        if (sh <= 0) begin
            q = m << (-sh);
        end else if (sh >= 64) begin
            q = (sh == 64 && m > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
        end else begin
            rem = m & ((64'd1 << sh) - 64'd1);
            hlf = 64'd1 << (sh - 1);
            q   = m >> sh;
            if (rem > hlf || (rem == hlf && q[0])) q = q + 64'd1;
        end
        r = (base << fb) + q;
        if (r >= infv) r = infv;
        return r[31:0] | (32'(sgn) << sbit);
    endfunction

    function automatic void split_single(input bit [31:0] b, output bit s,
                                         output bit [63:0] m, output int e);
        s = b[31];
        if (b[30:23] == 8'd0) begin
            m = 64'(b[22:0]);
            e = -149;
        end else begin
            m = 64'({1'b1, b[22:0]});
            e = int'(b[30:23]) - 150;
        end
    endfunction

    function automatic bit [31:0] scale_offset_fma(bit [15:0] pix, bit [31:0] sc,
                                                   bit [31:0] of);
        bit        sc_nan, of_nan, sc_inf, of_inf, ss, so, sa, sb, sr;
        bit [63:0] ms, mo, a, b, m;
        int        es, eo, ea, eb, d, lz;
        sc_nan = sc[30:23] == 8'hFF && sc[22:0] != 0;
        of_nan = of[30:23] == 8'hFF && of[22:0] != 0;
        sc_inf = sc[30:0] == 31'h7F80_0000;
        of_inf = of[30:0] == 31'h7F80_0000;
        // infinity times zero wins even over a quiet NaN offset
        if (of_nan && !of[22]) return of | QUIET_BIT;
        if (sc_nan && !sc[22]) return sc | QUIET_BIT;
        if (of_nan && sc_inf && pix == 0) return DEFAULT_NAN;
        if (of_nan) return of;
        if (sc_nan) return sc;
        if (sc_inf) begin
            if (pix == 0) return DEFAULT_NAN;
            if (of_inf && (of[31] ^ sc[31])) return DEFAULT_NAN;
            return sc;
        end
        if (of_inf) return of;
        split_single(sc, ss, ms, es);
        split_single(of, so, mo, eo);
        a = ms * 64'(pix);
        if (a == 0 && mo == 0) return (ss && so) ? 32'h8000_0000 : 32'h0;
        if (a == 0) return of;
        if (mo == 0) return pack_rounded(ss, a, es, 23, 127, 31);
        lz = 62 - msb_pos(a);  a = a << lz;  es = es - lz;
        lz = 62 - msb_pos(mo); mo = mo << lz; eo = eo - lz;
        if (es >= eo) begin
            ea = es; sa = ss; b = mo; eb = eo; sb = so;
        end else begin
            b = a; eb = es; sb = ss; a = mo; ea = eo; sa = so;
        end
        d = ea - eb;
        if (d >= 63) b = 64'd1;
        else if (d > 0) b = (b >> d) | 64'((b & ((64'd1 << d) - 64'd1)) != 0);
        if (sa == sb) begin
            m = a + b; sr = sa;
        end else if (a >= b) begin
            m = a - b; sr = sa;
        end else begin
            m = b - a; sr = sb;
        end
        if (m == 0) return 32'h0;
        return pack_rounded(sr, m, ea, 23, 127, 31);
    endfunction

    function automatic bit [31:0] single_to_half(bit [31:0] f);
        bit        s;
        bit [63:0] m;
        int        e;
        if (f[30:23] == 8'hFF) begin
            if (f[22:0] != 0) return {16'h0, f[31], 15'h7E00 | 15'(f[22:13])};
            return {16'h0, f[31], 15'h7C00};
        end
        split_single(f, s, m, e);
        if (m == 0) return {16'h0, s, 15'h0};
        return 32'(pack_rounded(s, m, e, 10, 15, 15) & 32'hFFFF);
    endfunction

    function automatic bit [31:0] predict_pixel(bit [15:0] raw);
        bit [15:0] pix;
        bit [31:0] r;
        pix = cur_word ? raw : {8'h00, raw[7:0]};
        r   = scale_offset_fma(pix, cur_scale, cur_offset);
        return cur_half ? single_to_half(r) : r;
    endfunction

    function automatic bit [31:0] pick_float();
        bit [31:0] specials[10] = '{32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
                                    32'hFFA0_0001, 32'h7F80_0001, 32'h0000_0001,
                                    32'h7F7F_FFFF, 32'h8000_0000, 32'h0000_0000,
                                    32'h807F_FFFF};
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
            2: return {1'($urandom), 8'($urandom_range(0, 6)), 23'($urandom)};
            3: return {1'($urandom), 8'($urandom_range(235, 254)), 23'($urandom)};
            4: return specials[$urandom_range(0, 9)];
            default: return {1'($urandom), 8'($urandom_range(115, 140)), 23'($urandom)};
        endcase
    endfunction

    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SCALE:  cur_scale  = val;
            REG_OFFSET: cur_offset = val;
            REG_WORD:   cur_word   = val[0];
            REG_HALF:   cur_half   = val[0];
            default: ;
        endcase
    endtask

    task automatic set_all(bit [31:0] sc, bit [31:0] of, bit word, bit half);
        write_reg(REG_SCALE, sc);
        write_reg(REG_OFFSET, of);
        write_reg(REG_WORD, 32'(word));
        write_reg(REG_HALF, 32'(half));
    endtask

    task automatic queue_pixel(bit [15:0] pix, bit last);
        pixel_item_t it;
        it.pix  = pix;
        it.last = last;
        it.res  = predict_pixel(pix);
        pending_pixels.push_back(it);
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0 || expected_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // source side: hold the item until taken, then advance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back({pending_pixels[0].last, pending_pixels[0].res});
                void'(pending_pixels.pop_front());
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
                if (idling_on && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(0, 7);
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_pixels[0].pix;
                    s_tlast  <= pending_pixels[0].last;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sink side: random stall bursts, compare against the oldest expectation
    always @(posedge aclk) begin
        bit [32:0] want;
        cycles++;
        if (cycles > 400000) begin
            $display("== FAIL ==");
            $finish;
        end
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result %h", m_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want[31:0]) begin
                        $error("result_bits expected %h actual %h", want[31:0], m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want[32]) begin
                        $error("last_out expected %0d actual %0d", want[32], m_tlast);
                        errors++;
                    end
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_tready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                sink_stall = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: scale one, byte mode, upper byte ignored
        queue_pixel(16'hFF00, 1'b0);
        queue_pixel(16'h00FF, 1'b1);
        drain();
        // infinite scale with zero pixel, also over a quiet NaN offset
        set_all(32'h7F80_0000, 32'h7FC1_2345, 1'b1, 1'b0);
        queue_pixel(16'h0000, 1'b0);
        queue_pixel(16'h0001, 1'b1);
        drain();
        // opposite infinities, then signalling NaN offset
        set_all(32'hFF80_0000, 32'h7F80_0000, 1'b0, 1'b0);
        queue_pixel(16'h0002, 1'b0);
        queue_pixel(16'h0000, 1'b0);
        drain();
        write_reg(REG_OFFSET, 32'hFF80_0001);
        queue_pixel(16'h0005, 1'b1);
        drain();
        // signalling NaN scale, quiet NaN scale
        set_all(32'h7F80_0010, 32'h3F80_0000, 1'b0, 1'b1);
        queue_pixel(16'h0003, 1'b0);
        drain();
        write_reg(REG_SCALE, 32'hFFC0_0FFF);
        queue_pixel(16'h0004, 1'b0);
        drain();
        // exact cancellation gives +0; negative zeros stay negative
        set_all(32'h3F80_0000, 32'hC040_0000, 1'b0, 1'b0);
        queue_pixel(16'h0003, 1'b0);
        drain();
        set_all(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
        queue_pixel(16'hFFFF, 1'b0);
        queue_pixel(16'h0000, 1'b1);
        drain();
        // overflow in both modes, subnormal scale
        set_all(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1, 1'b0);
        queue_pixel(16'hFFFF, 1'b0);
        drain();
        set_all(32'h4780_0000, 32'h0000_0000, 1'b1, 1'b1);
        queue_pixel(16'hFFFF, 1'b1);
        queue_pixel(16'h0001, 1'b0);
        drain();
        set_all(32'h0000_0001, 32'h8000_0001, 1'b1, 1'b1);
        queue_pixel(16'hFFFF, 1'b0);
        queue_pixel(16'h0001, 1'b1);
        drain();

        for (int p = 0; p < 14; p++) begin
            if (p >= 12) idling_on = 1'b0;
            set_all(pick_float(), pick_float(), 1'($urandom), 1'($urandom));
            for (int i = 0; i < 65; i++)
                queue_pixel(16'($urandom), $urandom_range(0, 7) == 0);
            drain();
        end

        repeat (20) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/ipf_pkg.sv
design/ipf_cfg_regs.sv
design/ipf_mul_stage.sv
design/ipf_add_stage.sv
design/ipf_pack_stage.sv
design/int_pixel_to_float_scale_offset_top.sv
tb/tb_int_pixel_to_float_scale_offset_top.sv
